// ===== src/trg_pkg.sv =====
package trg_pkg;

  // Default sizes of the group table
  localparam int MAX_GROUPS_DEF = 16;
  localparam int MAX_COLS_DEF   = 16;

  // Fixed field widths
  localparam int VAL_W   = 32;
  localparam int DIFF_W  = VAL_W + 1;
  localparam int SUM_W   = 40;
  localparam int TOL_W   = 32;
  localparam int FIELD_W = 5;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOL   = 1'b1;

  // Register reset values
  localparam logic [FIELD_W-1:0] GROUP_LIMIT_RST = 5'd16;
  localparam logic [TOL_W-1:0]   MATCH_TOL_RST   = 32'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SCAN,
    ST_RESULT
  } trg_state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] element_value;
    logic                    first_of_matrix;
    logic                    last_of_row;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] group_number;
    logic               new_group;
    logic               overflow;
    logic               within_limit;
    logic [FIELD_W-1:0] distinct_count;
    logic               row_too_long;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic [SUM_W-1:0] value;
  } acc_wr_t;

  // Address width of a memory, at least one bit
  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ===== src/trg_in_if.sv =====
interface trg_in_if;
  import trg_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/trg_out_if.sv =====
interface trg_out_if;
  import trg_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/trg_ram.sv =====
module trg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [trg_pkg::addr_w(DEPTH)-1:0]    waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [trg_pkg::addr_w(DEPTH)-1:0]    raddr,
  output logic [WIDTH-1:0]                     rdata
);
  import trg_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/trg_acc.sv =====
module trg_acc (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic [trg_pkg::VAL_W-1:0]    x,
  input  logic [trg_pkg::VAL_W-1:0]    ref_word,
  input  logic [trg_pkg::SUM_W-1:0]    sum_in,
  input  logic [trg_pkg::TOL_W-1:0]    tol,
  output trg_pkg::acc_wr_t             wr,
  output logic                         below
);
  import trg_pkg::*;

  logic [DIFF_W-1:0] diff_s;
  logic [DIFF_W-1:0] diff_abs;
  logic [DIFF_W-1:0] diff_r;
  logic [SUM_W-1:0]  sum_r;
  logic              v_r;
  logic [SUM_W:0]    total;

  // Exact absolute difference of two signed words
  assign diff_s   = {x[VAL_W-1], x} - {ref_word[VAL_W-1], ref_word};
  assign diff_abs = diff_s[DIFF_W-1] ? (~diff_s + DIFF_W'(1)) : diff_s;

  assign below = sum_in < SUM_W'(tol);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_abs;
    sum_r  <= sum_in;
  end

  // Accumulate and saturate
  assign total    = {1'b0, sum_r} + (SUM_W + 1)'(diff_r);
  assign wr.en    = v_r;
  assign wr.value = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
endmodule

// ===== src/tolerant_row_grouper.sv =====
// Sequence: a request is taken in the idle state, then walks the G stored groups one per
//   cycle; none past the column limit. A row end adds a scan of the stored groups
//   and a result state, which waits until the output is free.
// A new element is taken only back in the idle state, once the last one is done.
// Reset: synchronous, active low; clears groups, flags and the row, limit 16,
//   tolerance 1 LSB. Reference words are not cleared.
module tolerant_row_grouper #(
  parameter int MAX_GROUPS = trg_pkg::MAX_GROUPS_DEF,
  parameter int MAX_COLS   = trg_pkg::MAX_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  trg_in_if.sink                        in_ch,
  trg_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [trg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trg_pkg::CFG_W-1:0]     cfg_data
);
  import trg_pkg::*;

  localparam int DEPTH = MAX_GROUPS * MAX_COLS;
  localparam int AW    = addr_w(DEPTH);
  localparam int AW1   = AW + 1;
  localparam int IW    = addr_w(MAX_GROUPS);
  localparam int GW    = $clog2(MAX_GROUPS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int WW    = (GW > FIELD_W) ? GW : FIELD_W;

  trg_state_t state_r, state_nxt;

  // Configuration
  logic [FIELD_W-1:0] limit_r;
  logic [TOL_W-1:0]   tol_r;

  // Table and row state
  logic [GW-1:0]         gcnt_r;
  logic [CW-1:0]         col_r;
  logic                  ovf_r;
  logic                  long_r;
  logic [MAX_GROUPS-1:0] svalid_r;

  // Current request
  logic [VAL_W-1:0] x_r;
  logic             last_r;

  // Walk / scan sequencer
  logic [GW-1:0]  issue_g_r;
  logic [AW1-1:0] base_r;
  logic           s1_v_r;
  logic [IW-1:0]  s1_g_r;
  logic           s1_sv_r;
  logic [IW-1:0]  s2_g_r;
  logic           matched_r;
  logic [IW-1:0]  match_g_r;

  // Result register
  logic      out_v_r;
  out_item_t out_d_r;

  // Control
  logic           in_take;
  logic [CW-1:0]  col_eff;
  logic           issue;
  logic           ref_we;
  logic           walk_done;
  logic           hit;
  logic           scan_miss;
  logic           out_free;
  logic           lim_ok;
  logic [AW1-1:0] slot_addr;
  logic [WW-1:0]  num_match;
  logic [WW-1:0]  num_new;

  // Memory ports
  logic [VAL_W-1:0] ref_rdata;
  logic [SUM_W-1:0] sum_rdata;
  logic [SUM_W-1:0] sum_eff;
  acc_wr_t          acc_wr;
  logic             below;

  assign in_take   = in_ch.valid && in_ch.ready;
  assign col_eff   = in_ch.data.first_of_matrix ? '0 : col_r;
  assign walk_done = (issue_g_r == gcnt_r) && !s1_v_r && !acc_wr.en;
  assign hit       = s1_v_r && below;
  assign scan_miss = (issue_g_r == gcnt_r) && !s1_v_r;
  assign out_free  = !out_v_r || out_ch.ready;
  assign sum_eff   = s1_sv_r ? sum_rdata : '0;

  // Candidate slot for the row in progress
  assign slot_addr = AW1'(gcnt_r) * AW1'(MAX_COLS) + AW1'(col_r);

  // Effective limit is the smaller of the register and the table size
  assign lim_ok    = (WW'(gcnt_r) < WW'(limit_r)) && (gcnt_r < GW'(MAX_GROUPS));
  assign num_match = WW'(match_g_r) + WW'(1);
  assign num_new   = WW'(gcnt_r) + WW'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (col_eff < CW'(MAX_COLS)) begin
            state_nxt = ST_WALK;
          end else if (in_ch.data.last_of_row) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = last_r ? ST_SCAN : ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (hit || scan_miss) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    issue       = 1'b0;
    ref_we      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_WALK: begin
        issue  = issue_g_r < gcnt_r;
        ref_we = gcnt_r < GW'(MAX_GROUPS);
      end
      ST_SCAN: begin
        issue = (issue_g_r < gcnt_r) && !hit;
      end
      ST_RESULT: begin
        issue = 1'b0;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= GROUP_LIMIT_RST;
      tol_r   <= MATCH_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GROUP_LIMIT: limit_r <= cfg_data[FIELD_W-1:0];
        CFG_MATCH_TOL:   tol_r   <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      gcnt_r    <= '0;
      col_r     <= '0;
      ovf_r     <= 1'b0;
      long_r    <= 1'b0;
      svalid_r  <= '0;
      issue_g_r <= '0;
      s1_v_r    <= 1'b0;
      matched_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issue;

      // Raise the result on leaving the result state, drop it once taken
      if (state_r == ST_RESULT && out_free) begin
        out_v_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_v_r <= 1'b0;
      end

      if (issue) begin
        issue_g_r <= issue_g_r + GW'(1);
      end

      // Mark a group's sum live once the accumulator writes it
      if (acc_wr.en) begin
        svalid_r[s2_g_r] <= 1'b1;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            issue_g_r <= '0;
            matched_r <= 1'b0;
            col_r     <= col_eff;
            // Start of matrix: drop groups, flags and any unfinished row
            if (in_ch.data.first_of_matrix) begin
              gcnt_r   <= '0;
              ovf_r    <= 1'b0;
              svalid_r <= '0;
              long_r   <= 1'b0;
            end else if (col_eff >= CW'(MAX_COLS)) begin
              long_r <= 1'b1;
            end
          end
        end
        ST_WALK: begin
          if (walk_done) begin
            col_r     <= col_r + CW'(1);
            issue_g_r <= '0;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            matched_r <= 1'b1;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            svalid_r <= '0;
            col_r    <= '0;
            long_r   <= 1'b0;
            if (!matched_r) begin
              if (lim_ok) begin
                gcnt_r <= gcnt_r + GW'(1);
              end else begin
                ovf_r <= 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_g_r  <= issue_g_r[IW-1:0];
    s1_sv_r <= svalid_r[issue_g_r[IW-1:0]];
    s2_g_r  <= s1_g_r;

    if (in_take) begin
      x_r    <= in_ch.data.element_value;
      last_r <= in_ch.data.last_of_row;
      base_r <= AW1'(col_eff);
    end else if (issue) begin
      base_r <= base_r + AW1'(MAX_COLS);
    end

    if (state_r == ST_SCAN && hit) begin
      match_g_r <= s1_g_r;
    end

    if (state_r == ST_RESULT && out_free) begin
      out_d_r.row_too_long <= long_r;
      if (matched_r) begin
        out_d_r.group_number   <= num_match[FIELD_W-1:0];
        out_d_r.new_group      <= 1'b0;
        out_d_r.overflow       <= 1'b0;
        out_d_r.within_limit   <= !ovf_r;
        out_d_r.distinct_count <= num_new[FIELD_W-1:0] - FIELD_W'(1);
      end else if (lim_ok) begin
        out_d_r.group_number   <= num_new[FIELD_W-1:0];
        out_d_r.new_group      <= 1'b1;
        out_d_r.overflow       <= 1'b0;
        out_d_r.within_limit   <= !ovf_r;
        out_d_r.distinct_count <= num_new[FIELD_W-1:0];
      end else begin
        out_d_r.group_number   <= '0;
        out_d_r.new_group      <= 1'b0;
        out_d_r.overflow       <= 1'b1;
        out_d_r.within_limit   <= 1'b0;
        out_d_r.distinct_count <= num_new[FIELD_W-1:0] - FIELD_W'(1);
      end
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

  // Reference rows: candidate word written while its column is walked
  trg_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (slot_addr[AW-1:0]),
    .wdata (x_r),
    .raddr (base_r[AW-1:0]),
    .rdata (ref_rdata)
  );

  // Running difference sums, one per group
  trg_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_GROUPS)
  ) u_sum_ram (
    .clk   (clk),
    .we    (acc_wr.en),
    .waddr (s2_g_r),
    .wdata (acc_wr.value),
    .raddr (issue_g_r[IW-1:0]),
    .rdata (sum_rdata)
  );

  // Shared difference, accumulate and compare unit
  trg_acc u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (s1_v_r && (state_r == ST_WALK)),
    .x        (x_r),
    .ref_word (ref_rdata),
    .sum_in   (sum_eff),
    .tol      (tol_r),
    .wr       (acc_wr),
    .below    (below)
  );

  // Group count never passes the table size
  a_gcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gcnt_r <= GW'(MAX_GROUPS))
    else $error("group count beyond table size");

  // A new request is taken only with the walk pipeline empty
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !s1_v_r && !acc_wr.en)
    else $error("request taken with walk in flight");

  // Sums are written only while walking
  a_sum_wr_walk: assert property (@(posedge clk) disable iff (!rst_n)
    acc_wr.en |-> state_r == ST_WALK)
    else $error("difference sum written outside walk");

  // A result never both opens a group and overflows
  a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_d_r.new_group && out_d_r.overflow))
    else $error("result opened a group and overflowed");
endmodule
